### rtl/tess_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tess_pkg
// Widths, the reset step length and the queue word type of the step splitter.
// ----------------------------------------------------------------------------
package tess_pkg;

  localparam int TAG_W  = 8;
  localparam int TIME_W = 32;
  localparam int DUR_W  = 32;
  localparam int VAL_W  = 8;
  localparam int N_VALS = 6;
  localparam int LEN_W  = 20;
  localparam logic [LEN_W-1:0] LEN_RESET = 20'd50000;

  // step count up to 64, remainder of the time split below the step count
  localparam int STEP_W = 7;
  // divider: dividend holds 2*duration + length, shifted divisor holds n << 31
  localparam int REM_W  = 34;
  localparam int Q_W    = 32;
  localparam int DSH_W  = STEP_W + Q_W - 1;
  localparam int CNT_W  = 6;

  typedef logic [N_VALS-1:0][VAL_W-1:0] vals_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [LEN_W-1:0]  len;
    logic [TIME_W-1:0] prev;
    logic              neg;
    logic [Q_W-1:0]    quo;
    logic [STEP_W-1:0] rem;
    logic [STEP_W-1:0] n;
    logic              clipped;
    vals_t             vals;
  } entry_t;

endpackage
`default_nettype wire

### rtl/tess_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tess_evt_if / tess_row_if
// Valid/ready channels for input events and output tick rows.
// ----------------------------------------------------------------------------
interface tess_evt_if;
  logic        valid;
  logic        ready;
  logic [7:0]  in_tag;
  logic [31:0] in_duration;
  logic [31:0] in_end_time;
  logic [7:0]  in_value_0;
  logic [7:0]  in_value_1;
  logic [7:0]  in_value_2;
  logic [7:0]  in_value_3;
  logic [7:0]  in_value_4;
  logic [7:0]  in_value_5;

  modport source (
    output valid, in_tag, in_duration, in_end_time,
    output in_value_0, in_value_1, in_value_2, in_value_3, in_value_4, in_value_5,
    input  ready
  );
  modport sink (
    input  valid, in_tag, in_duration, in_end_time,
    input  in_value_0, in_value_1, in_value_2, in_value_3, in_value_4, in_value_5,
    output ready
  );
endinterface

interface tess_row_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_tag;
  logic [19:0] out_step_length;
  logic [31:0] out_time;
  logic [7:0]  out_value_0;
  logic [7:0]  out_value_1;
  logic [7:0]  out_value_2;
  logic [7:0]  out_value_3;
  logic [7:0]  out_value_4;
  logic [7:0]  out_value_5;
  logic        last;
  logic        clipped;

  modport source (
    output valid, out_tag, out_step_length, out_time,
    output out_value_0, out_value_1, out_value_2, out_value_3, out_value_4, out_value_5,
    output last, clipped,
    input  ready
  );
  modport sink (
    input  valid, out_tag, out_step_length, out_time,
    input  out_value_0, out_value_1, out_value_2, out_value_3, out_value_4, out_value_5,
    input  last, clipped,
    output ready
  );
endinterface
`default_nettype wire

### rtl/tess_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tess_div
// Restoring divider, one quotient bit per cycle, caller sets the bit count.
// ----------------------------------------------------------------------------
module tess_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [tess_pkg::REM_W-1:0]  num,
  input  wire logic [tess_pkg::DSH_W-1:0]  dsh,
  input  wire logic [tess_pkg::CNT_W-1:0]  bits,
  output logic                             done,
  output logic [tess_pkg::Q_W-1:0]         quo,
  output logic [tess_pkg::REM_W-1:0]       rem
);

  logic                         busy_r;
  logic                         done_r;
  logic [tess_pkg::CNT_W-1:0]   cnt_r;
  logic [tess_pkg::REM_W-1:0]   rem_r;
  logic [tess_pkg::DSH_W-1:0]   dsh_r;
  logic [tess_pkg::Q_W-1:0]     quo_r;
  logic                         ge;

  assign ge   = tess_pkg::DSH_W'(rem_r) >= dsh_r;
  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= bits;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == tess_pkg::CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      dsh_r <= dsh;
      quo_r <= '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - dsh_r[tess_pkg::REM_W-1:0];
      end
      dsh_r <= dsh_r >> 1;
      quo_r <= {quo_r[tess_pkg::Q_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

### rtl/tess_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tess_front
// Accept events, work out step count and time split, queue words if count > 0.
// ----------------------------------------------------------------------------
module tess_front #(
  parameter int MAX_STEPS = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  tess_evt_if.sink                           in_evt,
  input  wire logic                          cfg_we,
  input  wire logic [tess_pkg::LEN_W-1:0]    cfg_wdata,
  output logic                               ent_valid,
  input  wire logic                          ent_ready,
  output tess_pkg::entry_t                   ent
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LIM   = 3'd1;
  localparam logic [2:0] ST_CHK   = 3'd2;
  localparam logic [2:0] ST_STEPS = 3'd3;
  localparam logic [2:0] ST_DIFF  = 3'd4;
  localparam logic [2:0] ST_PUSH  = 3'd5;

  localparam int LIM_MUL = 2 * (MAX_STEPS + 1);
  localparam logic [tess_pkg::STEP_W-1:0] N_MAX = tess_pkg::STEP_W'(MAX_STEPS);

  logic [2:0]                     state_r, state_nxt;
  logic [tess_pkg::TIME_W-1:0]    prev_r;
  logic [tess_pkg::LEN_W-1:0]     len_r;

  logic [tess_pkg::TAG_W-1:0]     tag_r;
  logic [tess_pkg::DUR_W-1:0]     dur_r;
  logic [tess_pkg::TIME_W-1:0]    end_r;
  tess_pkg::vals_t                vals_r;
  logic [tess_pkg::LEN_W-1:0]     len_eff_r;
  logic [tess_pkg::TIME_W-1:0]    prev_snap_r;
  logic [tess_pkg::REM_W-1:0]     num_r;
  logic [tess_pkg::REM_W-1:0]     lim_r;
  logic [tess_pkg::TIME_W-1:0]    mag_r;
  logic                           neg_r;
  logic [tess_pkg::STEP_W-1:0]    n_r;
  logic                           clip_r;
  logic [tess_pkg::Q_W-1:0]       quo_r;
  logic [tess_pkg::STEP_W-1:0]    rem_r;

  logic                           accept;
  logic                           div_start;
  logic [tess_pkg::REM_W-1:0]     div_num;
  logic [tess_pkg::DSH_W-1:0]     div_dsh;
  logic [tess_pkg::CNT_W-1:0]     div_bits;
  logic                           div_done;
  logic [tess_pkg::Q_W-1:0]       div_quo;
  logic [tess_pkg::REM_W-1:0]     div_rem;
  logic                           over;
  logic [tess_pkg::STEP_W-1:0]    n_sel;

  assign in_evt.ready = (state_r == ST_IDLE);
  assign accept       = in_evt.valid && in_evt.ready;
  assign over         = num_r >= lim_r;
  assign n_sel        = (state_r == ST_CHK) ? N_MAX : div_quo[tess_pkg::STEP_W-1:0];

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    div_num   = tess_pkg::REM_W'(mag_r);
    div_dsh   = tess_pkg::DSH_W'(n_sel) << (tess_pkg::Q_W - 1);
    div_bits  = tess_pkg::CNT_W'(tess_pkg::Q_W);
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_LIM;
      end
      ST_LIM: state_nxt = ST_CHK;
      ST_CHK: begin
        div_start = 1'b1;
        if (over) begin
          state_nxt = ST_DIFF;
        end else begin
          div_num   = num_r;
          div_dsh   = tess_pkg::DSH_W'({len_eff_r, 1'b0}) << (tess_pkg::STEP_W - 1);
          div_bits  = tess_pkg::CNT_W'(tess_pkg::STEP_W);
          state_nxt = ST_STEPS;
        end
      end
      ST_STEPS: begin
        if (div_done) begin
          if (n_sel == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            div_start = 1'b1;
            state_nxt = ST_DIFF;
          end
        end
      end
      ST_DIFF: begin
        if (div_done) state_nxt = ST_PUSH;
      end
      ST_PUSH: begin
        if (ent_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      prev_r  <= '0;
      len_r   <= tess_pkg::LEN_RESET;
    end else begin
      state_r <= state_nxt;
      if (accept) prev_r <= in_evt.in_end_time;
      if (cfg_we) len_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tag_r       <= in_evt.in_tag;
      dur_r       <= in_evt.in_duration;
      end_r       <= in_evt.in_end_time;
      vals_r      <= {in_evt.in_value_5, in_evt.in_value_4, in_evt.in_value_3,
                      in_evt.in_value_2, in_evt.in_value_1, in_evt.in_value_0};
      len_eff_r   <= (len_r == '0) ? tess_pkg::LEN_W'(1) : len_r;
      prev_snap_r <= prev_r;
    end
    if (state_r == ST_LIM) begin
      num_r <= tess_pkg::REM_W'({dur_r, 1'b0}) + tess_pkg::REM_W'(len_eff_r);
      lim_r <= tess_pkg::REM_W'(len_eff_r) * tess_pkg::REM_W'(LIM_MUL);
      neg_r <= end_r < prev_snap_r;
      mag_r <= (end_r < prev_snap_r) ? prev_snap_r - end_r : end_r - prev_snap_r;
    end
    if (state_r == ST_CHK) begin
      clip_r <= over;
      if (over) n_r <= N_MAX;
    end
    if (state_r == ST_STEPS && div_done) n_r <= n_sel;
    if (state_r == ST_DIFF && div_done) begin
      quo_r <= div_quo;
      rem_r <= div_rem[tess_pkg::STEP_W-1:0];
    end
  end

  tess_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .dsh   (div_dsh),
    .bits  (div_bits),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  assign ent_valid   = (state_r == ST_PUSH);
  assign ent.tag     = tag_r;
  assign ent.len     = len_eff_r;
  assign ent.prev    = prev_snap_r;
  assign ent.neg     = neg_r;
  assign ent.quo     = quo_r;
  assign ent.rem     = rem_r;
  assign ent.n       = n_r;
  assign ent.clipped = clip_r;
  assign ent.vals    = vals_r;

endmodule
`default_nettype wire

### rtl/tess_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tess_queue
// Two-word queue between the front and the back.
// ----------------------------------------------------------------------------
module tess_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_valid,
  output logic                   wr_ready,
  input  tess_pkg::entry_t       wr_data,
  output logic                   rd_valid,
  input  wire logic              rd_ready,
  output tess_pkg::entry_t       rd_data
);

  tess_pkg::entry_t mem_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       cnt_r;
  logic             push;
  logic             pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule
`default_nettype wire

### rtl/tess_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tess_back
// Take queued words, emit one tick row per cycle unless stalled, registered.
// ----------------------------------------------------------------------------
module tess_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              ent_valid,
  output logic                   ent_ready,
  input  tess_pkg::entry_t       ent,
  tess_row_if.source             out_row
);

  tess_pkg::entry_t               cur_r;
  logic                           busy_r;
  logic [tess_pkg::STEP_W-1:0]    s_r;
  logic [tess_pkg::STEP_W-1:0]    acc_r;
  logic [tess_pkg::TIME_W-1:0]    t_r;
  logic [tess_pkg::Q_W-1:0]       q1_r;

  logic                           out_valid_r;
  logic [tess_pkg::TAG_W-1:0]     out_tag_r;
  logic [tess_pkg::LEN_W-1:0]     out_len_r;
  logic [tess_pkg::TIME_W-1:0]    out_time_r;
  tess_pkg::vals_t                out_vals_r;
  logic                           out_last_r;
  logic                           out_clip_r;

  logic [tess_pkg::STEP_W:0]      acc_sum;
  logic                           carry;
  logic [tess_pkg::STEP_W-1:0]    acc_nxt;
  logic [tess_pkg::Q_W-1:0]       inc;
  logic [tess_pkg::TIME_W-1:0]    t_nxt;
  logic                           emit;
  logic                           is_last;
  logic                           load;

  assign ent_ready = !busy_r;
  assign load      = ent_valid && !busy_r;
  assign emit      = busy_r && (!out_valid_r || out_row.ready);
  assign is_last   = (s_r == cur_r.n);

  always_comb begin
    acc_sum = {1'b0, acc_r} + {1'b0, cur_r.rem};
    carry   = acc_sum >= {1'b0, cur_r.n};
    acc_nxt = carry ? tess_pkg::STEP_W'(acc_sum - {1'b0, cur_r.n})
                    : acc_sum[tess_pkg::STEP_W-1:0];
    inc     = carry ? q1_r : cur_r.quo;
    t_nxt   = cur_r.neg ? t_r - inc : t_r + inc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        busy_r <= 1'b1;
      end else if (emit && is_last) begin
        busy_r <= 1'b0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_row.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_r <= ent;
      q1_r  <= ent.quo + 1'b1;
      t_r   <= ent.prev;
      acc_r <= '0;
      s_r   <= tess_pkg::STEP_W'(1);
    end else if (emit) begin
      t_r   <= t_nxt;
      acc_r <= acc_nxt;
      s_r   <= s_r + 1'b1;
    end
    if (emit) begin
      out_tag_r  <= cur_r.tag;
      out_len_r  <= cur_r.len;
      out_time_r <= t_nxt;
      out_vals_r <= is_last ? cur_r.vals : '0;
      out_last_r <= is_last;
      out_clip_r <= cur_r.clipped;
    end
  end

  assign out_row.valid           = out_valid_r;
  assign out_row.out_tag         = out_tag_r;
  assign out_row.out_step_length = out_len_r;
  assign out_row.out_time        = out_time_r;
  assign out_row.out_value_0     = out_vals_r[0];
  assign out_row.out_value_1     = out_vals_r[1];
  assign out_row.out_value_2     = out_vals_r[2];
  assign out_row.out_value_3     = out_vals_r[3];
  assign out_row.out_value_4     = out_vals_r[4];
  assign out_row.out_value_5     = out_vals_r[5];
  assign out_row.last            = out_last_r;
  assign out_row.clipped         = out_clip_r;

`ifndef SYNTH
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (s_r != '0) && (s_r <= cur_r.n))
    else $error("tick index outside step count");

  a_acc_below_n: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> acc_r < cur_r.n)
    else $error("split remainder not below step count");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    emit && is_last |=> !busy_r && out_row.last)
    else $error("run did not end on its final row");

  a_zero_vals: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_last_r |-> out_vals_r == '0)
    else $error("payload on a row that is not final");
`endif

endmodule
`default_nettype wire

### rtl/timed_event_step_splitter_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// timed_event_step_splitter_unit
// Split timed events into tick rows with interpolated times.
// ----------------------------------------------------------------------------
// An event is taken and then held by the front for its division work: a
// bit-serial division for the rounded step count (skipped when the count
// saturates at MAX_STEPS) and one for splitting the time span; the front
// takes no new event until its word is queued or its count is zero. The
// back emits one row per cycle unless out_row stalls, with a load between
// events, behind a two-word queue, so sustained rate is set by the shared
// divider for short runs and by the row count for long ones. cfg_we
// writes step_length (0 acts as 1); write it only while the block is idle.
// ----------------------------------------------------------------------------
module timed_event_step_splitter_unit #(
  parameter int MAX_STEPS = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  tess_evt_if.sink                           in_evt,
  tess_row_if.source                         out_row,
  input  wire logic                          cfg_we,
  input  wire logic [tess_pkg::LEN_W-1:0]    cfg_wdata
);

  logic              f_valid;
  logic              f_ready;
  tess_pkg::entry_t  f_data;
  logic              b_valid;
  logic              b_ready;
  tess_pkg::entry_t  b_data;

  tess_front #(
    .MAX_STEPS (MAX_STEPS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_evt    (in_evt),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .ent_valid (f_valid),
    .ent_ready (f_ready),
    .ent       (f_data)
  );

  tess_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_data),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_data  (b_data)
  );

  tess_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .ent_valid (b_valid),
    .ent_ready (b_ready),
    .ent       (b_data),
    .out_row   (out_row)
  );

endmodule
`default_nettype wire
